@@ hdl/fcos_pkg.sv @@
// fcos_pkg: types, codes, field offsets and the milliamp scaling table
// shared by the overcurrent supervisor, its step logic and its checker
// no dependencies
package fcos_pkg;

  localparam int DEF_NUM_CHANNELS = 5;
  localparam int MAX_CHANNELS     = 8;

  localparam int ADC_W      = 12;
  localparam int CUR_W      = 13;
  localparam int SCALE_W    = 16;
  localparam int Q_FRAC     = 15;
  localparam int PRESET_W   = 16;
  localparam int CFG_DATA_W = 16;

  localparam logic [CUR_W-1:0]    LIMIT_RESET     = 13'd3000;
  localparam logic [PRESET_W-1:0] COUNTDOWN_RESET = 16'd60;

  // unsigned q1.15 gain per channel, unity for channel 0 and beyond the fifth
  localparam logic [SCALE_W-1:0] SCALE_Q15 [MAX_CHANNELS] = '{
    16'd32768, 16'd49381, 16'd50127, 16'd49952,
    16'd49631, 16'd32768, 16'd32768, 16'd32768
  };

  // input tdata layout
  localparam int IN_RUN     = 0;
  localparam int IN_STOP    = 1;
  localparam int IN_EXPIRED = 2;
  localparam int IN_ADC     = 3;

  // output tdata layout
  localparam int OUT_RUN_STATE = 0;
  localparam int OUT_ENABLE    = 2;
  localparam int OUT_BEEP      = 3;
  localparam int OUT_TLOAD     = 5;
  localparam int OUT_PRESET    = 6;
  localparam int OUT_TCMD      = 22;
  localparam int OUT_STATUS    = 24;

  typedef enum logic [1:0] {
    ST_WAIT = 2'd0,
    ST_RUN  = 2'd1,
    ST_OC   = 2'd2,
    ST_STOP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CH_WAIT = 2'd0,
    CH_RUN  = 2'd1,
    CH_OC   = 2'd2
  } chan_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  localparam logic [1:0] BEEP_NONE  = 2'd0;
  localparam logic [1:0] BEEP_SHORT = 2'd1;
  localparam logic [1:0] BEEP_ALERT = 2'd2;
  localparam logic [1:0] BEEP_FAULT = 2'd3;

  typedef struct packed {
    logic run_key;
    logic stop_key;
    logic timer_expired;
  } keys_t;

  typedef struct packed {
    mode_t                run_state;
    logic                 output_enable;
    logic [1:0]           beep_code;
    logic                 timer_load;
    logic [PRESET_W-1:0]  timer_preset;
    cmd_t                 timer_command;
  } res_ctrl_t;

  function automatic logic [CUR_W-1:0] scale_to_ma(input logic [ADC_W-1:0] raw,
                                                   input logic [SCALE_W-1:0] k);
    logic [ADC_W+SCALE_W-1:0] prod;
    prod = {{SCALE_W{1'b0}}, raw} * {{ADC_W{1'b0}}, k};
    return prod[Q_FRAC +: CUR_W];
  endfunction

endpackage

@@ hdl/five_channel_overcurrent_supervisor.sv @@
// five_channel_overcurrent_supervisor: top level, poll stream in, result stream out
// depends on fcos_pkg and fcos_core
//
// One input transfer is one 10 ms poll (run key, stop key, timer expired and
// one raw 12-bit sample per channel); each poll gives exactly one result
// transfer. Samples are turned into milliamps by a fixed q1.15 gain per
// channel as they enter the input register; the supervisor step (limit
// compares, four-state sequencing, beeper and countdown commands) then runs
// combinationally into the result register. Throughput is one poll per
// clock while results are taken. A stalled result holds the result
// register and, once the input register is full too, s_tready drops. Limits
// and the countdown preset are written through the cfg port (index
// 0..NUM_CHANNELS-1 limits in mA, index NUM_CHANNELS the countdown preset,
// other indices ignored); the user must write them only while no poll is in
// flight, which the block does not enforce. Key releases are waited for as
// held states lasting one or more polls, never by stalling the stream.
module five_channel_overcurrent_supervisor #(
  parameter int NUM_CHANNELS = fcos_pkg::DEF_NUM_CHANNELS,
  localparam int IN_W      = ((3 + fcos_pkg::ADC_W * NUM_CHANNELS + 7) / 8) * 8,
  localparam int OUT_W     = ((24 + 2 * NUM_CHANNELS + 7) / 8) * 8,
  localparam int CFG_IDX_W = $clog2(NUM_CHANNELS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  // poll stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // run_key, stop_key, timer_expired, adc_ch0 .. adc_chN-1 (12 bits each), zero fill
  input  logic [IN_W-1:0]                 s_tdata,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // run_state (2), output_enable, beep_code (2), timer_load, timer_preset (16),
  // timer_command (2), status_ch0 .. status_chN-1 (2 bits each), zero fill
  output logic [OUT_W-1:0]                m_tdata,
  // configuration writes
  input  logic                            cfg_write,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [fcos_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fcos_pkg::*;

  // configuration registers
  logic [CUR_W-1:0]    limit [NUM_CHANNELS];
  logic [PRESET_W-1:0] countdown;

  // input register, currents already in milliamps
  logic             in_valid;
  keys_t            keys_q;
  logic [CUR_W-1:0] cur_q [NUM_CHANNELS];
  logic [CUR_W-1:0] scaled [NUM_CHANNELS];

  logic      advance;
  logic      step_en;
  res_ctrl_t ctrl;
  chan_t     status [NUM_CHANNELS];
  logic [OUT_W-1:0] res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) limit[i] <= LIMIT_RESET;
      countdown <= COUNTDOWN_RESET;
    end else if (cfg_write) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) limit[i] <= cfg_data[CUR_W-1:0];
      end
      if (cfg_index == CFG_IDX_W'(NUM_CHANNELS)) countdown <= cfg_data[PRESET_W-1:0];
    end
  end

  // one fixed-gain multiply per channel ahead of the input register
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_scale
    assign scaled[g] = scale_to_ma(s_tdata[IN_ADC + ADC_W * g +: ADC_W], SCALE_Q15[g]);
  end

  // the result register frees when empty or when its transfer completes
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step_en  = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      keys_q.run_key       <= s_tdata[IN_RUN];
      keys_q.stop_key      <= s_tdata[IN_STOP];
      keys_q.timer_expired <= s_tdata[IN_EXPIRED];
      for (int i = 0; i < NUM_CHANNELS; i++) cur_q[i] <= scaled[i];
    end
  end

  fcos_core #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step_en    (step_en),
    .keys       (keys_q),
    .sample_ma  (cur_q),
    .limit      (limit),
    .countdown  (countdown),
    .ctrl       (ctrl),
    .status_out (status)
  );

  // result packing
  always_comb begin
    res_data = '0;
    res_data[OUT_RUN_STATE +: 2]      = ctrl.run_state;
    res_data[OUT_ENABLE]              = ctrl.output_enable;
    res_data[OUT_BEEP +: 2]           = ctrl.beep_code;
    res_data[OUT_TLOAD]               = ctrl.timer_load;
    res_data[OUT_PRESET +: PRESET_W]  = ctrl.timer_preset;
    res_data[OUT_TCMD +: 2]           = ctrl.timer_command;
    for (int i = 0; i < NUM_CHANNELS; i++) res_data[OUT_STATUS + 2 * i +: 2] = status[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) m_tdata <= res_data;
  end

endmodule

@@ hdl/fcos_core.sv @@
// fcos_core: supervisor state and the per-poll step logic
// depends on fcos_pkg
module fcos_core #(
  parameter int NUM_CHANNELS = fcos_pkg::DEF_NUM_CHANNELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_en,
  input  fcos_pkg::keys_t             keys,
  input  logic [fcos_pkg::CUR_W-1:0]  sample_ma [NUM_CHANNELS],
  input  logic [fcos_pkg::CUR_W-1:0]  limit [NUM_CHANNELS],
  input  logic [fcos_pkg::PRESET_W-1:0] countdown,
  output fcos_pkg::res_ctrl_t         ctrl,
  output fcos_pkg::chan_t             status_out [NUM_CHANNELS]
);
  import fcos_pkg::*;

  mode_t            mode, mode_next;
  logic             await_run, await_run_next;
  logic             await_stop, await_stop_next;
  logic             outputs_on, outputs_on_next;
  chan_t            status [NUM_CHANNELS];
  chan_t            status_next [NUM_CHANNELS];
  logic [CUR_W-1:0] current [NUM_CHANNELS];
  logic [CUR_W-1:0] current_next [NUM_CHANNELS];

  logic                    sample_en;
  logic                    chk_en;
  logic [NUM_CHANNELS-1:0] over;
  logic                    any_over;
  logic [1:0]              beep;
  logic                    tload;
  cmd_t                    tcmd;

  // currents are refreshed only outside the key holds in waiting and running
  assign sample_en = !await_stop && !await_run && (mode == ST_WAIT || mode == ST_RUN);
  // run-state checks: on a free running poll and on the run release poll
  assign chk_en    = !await_stop && !keys.run_key && (mode == ST_RUN);

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      current_next[i] = sample_en ? sample_ma[i] : current[i];
      over[i]         = current_next[i] > limit[i];
    end
  end

  assign any_over = |over;

  // next state
  always_comb begin
    mode_next       = mode;
    await_run_next  = await_run;
    await_stop_next = await_stop;
    outputs_on_next = outputs_on;
    for (int i = 0; i < NUM_CHANNELS; i++) status_next[i] = status[i];

    if (await_stop) begin
      if (!keys.stop_key) await_stop_next = 1'b0;
    end else if (await_run) begin
      if (!keys.run_key) begin
        await_run_next = 1'b0;
        case (mode)
          ST_WAIT: begin
            mode_next       = ST_RUN;
            outputs_on_next = 1'b1;
            for (int i = 0; i < NUM_CHANNELS; i++) status_next[i] = CH_RUN;
          end
          ST_RUN: begin
            mode_next       = ST_STOP;
            outputs_on_next = 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) status_next[i] = CH_WAIT;
          end
          default: begin
            mode_next       = ST_WAIT;
            outputs_on_next = 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) status_next[i] = CH_WAIT;
          end
        endcase
      end
    end else begin
      case (mode)
        ST_WAIT: if (keys.run_key && !keys.stop_key) await_run_next = 1'b1;
        default: if (keys.run_key) await_run_next = 1'b1;
      endcase
    end

    // later checks override earlier ones
    if (chk_en) begin
      if (keys.timer_expired) begin
        mode_next       = ST_WAIT;
        outputs_on_next = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) status_next[i] = CH_WAIT;
      end
      if (any_over) begin
        mode_next       = ST_OC;
        outputs_on_next = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) status_next[i] = over[i] ? CH_OC : CH_WAIT;
      end
      if (keys.stop_key) begin
        mode_next       = ST_STOP;
        outputs_on_next = 1'b0;
        await_stop_next = 1'b1;
        for (int i = 0; i < NUM_CHANNELS; i++) status_next[i] = CH_WAIT;
      end
    end
  end

  // per-poll outputs
  always_comb begin
    beep  = BEEP_NONE;
    tload = 1'b0;
    tcmd  = CMD_NONE;

    if (await_stop) begin
      if (keys.stop_key && keys.run_key) beep = BEEP_FAULT;
    end else if (await_run) begin
      if (!keys.run_key) begin
        case (mode)
          ST_WAIT: begin
            tload = 1'b1;
            tcmd  = CMD_START;
          end
          ST_RUN:  tcmd = CMD_STOP;
          default: begin
            tload = 1'b1;
            tcmd  = CMD_STOP;
          end
        endcase
      end
    end else begin
      case (mode)
        ST_WAIT: begin
          tload = 1'b1;
          if (keys.run_key) beep = keys.stop_key ? BEEP_FAULT : BEEP_SHORT;
        end
        ST_RUN:  if (keys.run_key) beep = BEEP_SHORT;
        default: if (keys.run_key) beep = BEEP_ALERT;
      endcase
    end

    if (chk_en) begin
      if (keys.timer_expired || any_over || keys.stop_key) tcmd = CMD_STOP;
      if (keys.timer_expired) tload = 1'b1;
      if (keys.stop_key)           beep = keys.run_key ? BEEP_FAULT : BEEP_SHORT;
      else if (any_over)           beep = BEEP_FAULT;
      else if (keys.timer_expired) beep = BEEP_SHORT;
    end
  end

  always_comb begin
    ctrl.run_state     = mode_next;
    ctrl.output_enable = outputs_on_next;
    ctrl.beep_code     = beep;
    ctrl.timer_load    = tload;
    ctrl.timer_preset  = tload ? countdown : '0;
    ctrl.timer_command = tcmd;
    for (int i = 0; i < NUM_CHANNELS; i++) status_out[i] = status_next[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= ST_WAIT;
      await_run  <= 1'b0;
      await_stop <= 1'b0;
      outputs_on <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        status[i]  <= CH_WAIT;
        current[i] <= '0;
      end
    end else if (step_en) begin
      mode       <= mode_next;
      await_run  <= await_run_next;
      await_stop <= await_stop_next;
      outputs_on <= outputs_on_next;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        status[i]  <= status_next[i];
        current[i] <= current_next[i];
      end
    end
  end

endmodule

@@ hdl/fcos_checker.sv @@
// fcos_checker: port-level assertions on the supervisor result stream, bound to the top level
// depends on fcos_pkg and five_channel_overcurrent_supervisor
module fcos_checker #(
  parameter int NUM_CHANNELS = fcos_pkg::DEF_NUM_CHANNELS,
  localparam int OUT_W = ((24 + 2 * NUM_CHANNELS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);
  import fcos_pkg::*;

  // a stalled result transfer keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // outputs are driven exactly while running
  a_enable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_ENABLE] == (m_tdata[OUT_RUN_STATE +: 2] == ST_RUN))
    else $error("output enable disagrees with run state");

  // the preset field is zero unless a load is requested
  a_preset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[OUT_TLOAD] |-> m_tdata[OUT_PRESET +: PRESET_W] == '0)
    else $error("timer preset without load");

  // the alert beep only sounds from a fault state
  a_alert: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_BEEP +: 2] == BEEP_ALERT |->
      m_tdata[OUT_RUN_STATE +: 2] == ST_OC || m_tdata[OUT_RUN_STATE +: 2] == ST_STOP)
    else $error("alert beep outside a fault state");

endmodule

bind five_channel_overcurrent_supervisor fcos_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_fcos_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
